@@ rtl/srbt_pkg.sv @@
// ----------------------------------------------------------------------------
// srbt_pkg
// Shared types, codes and helper functions for the sram block test engine.
// ----------------------------------------------------------------------------
package srbt_pkg;

    localparam int BLOCK_WORDS_DEF    = 256;
    localparam int ADDRESS_BITS_DEF   = 18;
    localparam int PATTERN_LENGTH_DEF = 16;

    localparam int COUNT_W    = 11;
    localparam int BLOCK_W    = 10;
    localparam int DATA_W     = 16;
    localparam int ADDR_OUT_W = 18;
    localparam int CRC_W      = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'd1024;
    localparam logic [CRC_W-1:0]   CRC_INIT    = 16'hFFFF;

    // test phase codes
    localparam logic [1:0] PH_WRITE = 2'd0;
    localparam logic [1:0] PH_READ  = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    // access kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic                  test_done;
        logic [BLOCK_W-1:0]    block_number;
        logic                  block_pass;
        logic                  block_done;
        logic [DATA_W-1:0]     write_data;
        logic [ADDR_OUT_W-1:0] access_address;
        logic [1:0]            access_kind;
    } srbt_result_t;

    function automatic logic [DATA_W-1:0] pattern_word(input logic [3:0] idx);
        logic [DATA_W-1:0] w;
        begin
            case (idx)
                4'd0:    w = 16'h5A5A;
                4'd1:    w = 16'hA5A5;
                4'd2:    w = 16'h0101;
                4'd3:    w = 16'hEFEF;
                4'd4:    w = 16'hAAAA;
                4'd5:    w = 16'h5555;
                4'd6:    w = 16'hAAAA;
                4'd7:    w = 16'h5555;
                4'd8:    w = 16'h0011;
                4'd9:    w = 16'h0022;
                4'd10:   w = 16'h0044;
                4'd11:   w = 16'h0088;
                4'd12:   w = 16'h1100;
                4'd13:   w = 16'h2200;
                4'd14:   w = 16'h4400;
                default: w = 16'h8800;
            endcase
            return w;
        end
    endfunction

    // crc-16/ccitt, one byte folded in
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] data);
        logic [7:0] x;
        begin
            x = crc[15:8] ^ data;
            x = x ^ {4'b0, x[7:4]};
            return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
                   ^ {8'h00, x};
        end
    endfunction

endpackage

@@ rtl/sram_block_test_crc_signature.sv @@
// ----------------------------------------------------------------------------
// sram_block_test_crc_signature
// Memory self-test sequencer: writes a pattern per block, reads it back and
// compares crc-16/ccitt signatures of the low data bytes.
// ----------------------------------------------------------------------------
// output: a result is registered and is on m_axis in the cycle after its input transfer
// throughput: one item per cycle, sustained while m_axis_tready is high
// the sequencer step (address multiply, two chained crc byte folds) sits
// between the state registers and the result register
// reset: phase write, block 0, crc 0xffff, block_count 1024, output empty
module sram_block_test_crc_signature #(
    parameter int BLOCK_WORDS    = srbt_pkg::BLOCK_WORDS_DEF,
    parameter int ADDRESS_BITS   = srbt_pkg::ADDRESS_BITS_DEF,
    parameter int PATTERN_LENGTH = srbt_pkg::PATTERN_LENGTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [srbt_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,   // read_data
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // access_address[17:0], write_data[33:18], block_done[34], block_pass[35],
    // block_number[45:36], test_done[46], zero[47]
    output logic [47:0]                  m_axis_tdata,
    output logic [1:0]                   m_axis_tuser    // access_kind
);
    import srbt_pkg::*;

    localparam int OFF_W = $clog2(BLOCK_WORDS + 1);
    localparam int PAT_W = (PATTERN_LENGTH > 1) ? $clog2(PATTERN_LENGTH) : 1;

    logic [COUNT_W-1:0] block_count_reg;
    logic [1:0]         phase_reg, phase_next;
    logic [OFF_W-1:0]   word_offset_reg, word_offset_next;
    logic [PAT_W-1:0]   pat_idx_reg, pat_idx_next;
    logic [BLOCK_W-1:0] current_block_reg, current_block_next;
    logic [CRC_W-1:0]   running_crc_reg, running_crc_next;
    logic [CRC_W-1:0]   reference_crc_reg, reference_crc_next;
    logic               read_pending_reg, read_pending_next;
    logic               out_valid_reg;
    srbt_result_t       out_result_reg, step_result;
    logic               in_xfer;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    srbt_step #(
        .BLOCK_WORDS    (BLOCK_WORDS),
        .ADDRESS_BITS   (ADDRESS_BITS),
        .PATTERN_LENGTH (PATTERN_LENGTH),
        .OFF_W          (OFF_W),
        .PAT_W          (PAT_W)
    ) u_step (
        .phase              (phase_reg),
        .word_offset        (word_offset_reg),
        .pat_idx            (pat_idx_reg),
        .current_block      (current_block_reg),
        .running_crc        (running_crc_reg),
        .reference_crc      (reference_crc_reg),
        .read_pending       (read_pending_reg),
        .block_count        (block_count_reg),
        .read_data          (s_axis_tdata),
        .phase_next         (phase_next),
        .word_offset_next   (word_offset_next),
        .pat_idx_next       (pat_idx_next),
        .current_block_next (current_block_next),
        .running_crc_next   (running_crc_next),
        .reference_crc_next (reference_crc_next),
        .read_pending_next  (read_pending_next),
        .result             (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            block_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_WRITE;
            word_offset_reg   <= '0;
            pat_idx_reg       <= '0;
            current_block_reg <= '0;
            running_crc_reg   <= CRC_INIT;
            reference_crc_reg <= '0;
            read_pending_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg         <= phase_next;
            word_offset_reg   <= word_offset_next;
            pat_idx_reg       <= pat_idx_next;
            current_block_reg <= current_block_next;
            running_crc_reg   <= running_crc_next;
            reference_crc_reg <= reference_crc_next;
            read_pending_reg  <= read_pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.access_kind;
    assign m_axis_tdata  = {1'b0,
                            out_result_reg.test_done,
                            out_result_reg.block_number,
                            out_result_reg.block_pass,
                            out_result_reg.block_done,
                            out_result_reg.write_data,
                            out_result_reg.access_address};

    // once finished the sequencer never leaves the done phase
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("left done phase");

    // a pending read only exists inside the read phase after a read was issued
    a_pending_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        read_pending_reg |-> (phase_reg == PH_READ && word_offset_reg != '0))
        else $error("read pending outside read phase");

    // a block report never carries a memory access
    a_report_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && step_result.block_done) |-> step_result.access_kind == KIND_NONE)
        else $error("access issued in report item");

    // the write phase always starts on pattern entry zero
    a_pattern_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WRITE && word_offset_reg == '0) |-> pat_idx_reg == '0)
        else $error("pattern index out of step with offset");

endmodule

@@ rtl/srbt_step.sv @@
// ----------------------------------------------------------------------------
// srbt_step
// Next-state and result logic for one advance of the block test sequencer.
// ----------------------------------------------------------------------------
module srbt_step #(
    parameter int BLOCK_WORDS    = 256,
    parameter int ADDRESS_BITS   = 18,
    parameter int PATTERN_LENGTH = 16,
    parameter int OFF_W          = 9,
    parameter int PAT_W          = 4
) (
    input  logic [1:0]                  phase,
    input  logic [OFF_W-1:0]            word_offset,
    input  logic [PAT_W-1:0]            pat_idx,
    input  logic [srbt_pkg::BLOCK_W-1:0] current_block,
    input  logic [srbt_pkg::CRC_W-1:0]  running_crc,
    input  logic [srbt_pkg::CRC_W-1:0]  reference_crc,
    input  logic                        read_pending,
    input  logic [srbt_pkg::COUNT_W-1:0] block_count,
    input  logic [srbt_pkg::DATA_W-1:0] read_data,
    output logic [1:0]                  phase_next,
    output logic [OFF_W-1:0]            word_offset_next,
    output logic [PAT_W-1:0]            pat_idx_next,
    output logic [srbt_pkg::BLOCK_W-1:0] current_block_next,
    output logic [srbt_pkg::CRC_W-1:0]  running_crc_next,
    output logic [srbt_pkg::CRC_W-1:0]  reference_crc_next,
    output logic                        read_pending_next,
    output srbt_pkg::srbt_result_t      result
);
    import srbt_pkg::*;

    localparam int CALC_W = BLOCK_W + OFF_W + 1;
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_WORDS - 1);
    localparam logic [OFF_W-1:0] OFF_END  = OFF_W'(BLOCK_WORDS);
    localparam logic [PAT_W-1:0] PAT_LAST = PAT_W'(PATTERN_LENGTH - 1);

    logic [CRC_W-1:0]        crc_in;
    logic [PAT_W+3:0]        pat_ext;
    logic [DATA_W-1:0]       pat_word;
    logic [CALC_W-1:0]       addr_raw;
    logic [CALC_W-1:0]       addr_mask;
    logic [CALC_W+ADDR_OUT_W-1:0] addr_ext;
    logic [ADDR_OUT_W-1:0]   addr;
    logic [COUNT_W-1:0]      eff_count;
    logic [COUNT_W-1:0]      block_plus_one;

    always_comb
    begin
        for (int i = 0; i < CALC_W; i++)
        begin
            addr_mask[i] = (i < ADDRESS_BITS);
        end
    end

    assign addr_raw = (CALC_W'(current_block) * CALC_W'(BLOCK_WORDS))
                      + CALC_W'(word_offset);
    assign addr_ext = {{ADDR_OUT_W{1'b0}}, addr_raw & addr_mask};
    assign addr     = addr_ext[ADDR_OUT_W-1:0];

    assign pat_ext  = {4'b0000, pat_idx};
    assign pat_word = pattern_word(pat_ext[3:0]);

    // data of the previous read comes in with this item
    assign crc_in = read_pending ? crc_fold(running_crc, read_data[7:0]) : running_crc;

    assign eff_count = (block_count == '0) ? COUNT_W'(1) :
                       (block_count > COUNT_MAX) ? COUNT_MAX : block_count;
    assign block_plus_one = COUNT_W'(current_block) + COUNT_W'(1);

    always_comb
    begin
        phase_next         = phase;
        word_offset_next   = word_offset;
        pat_idx_next       = pat_idx;
        current_block_next = current_block;
        running_crc_next   = crc_in;
        reference_crc_next = reference_crc;
        read_pending_next  = 1'b0;
        result             = '0;

        unique case (phase)
            PH_WRITE:
            begin
                result.access_kind    = KIND_WRITE;
                result.access_address = addr;
                result.write_data     = pat_word;
                running_crc_next      = crc_fold(crc_in, pat_word[7:0]);
                pat_idx_next          = (pat_idx == PAT_LAST) ? '0 : pat_idx + PAT_W'(1);
                word_offset_next      = word_offset + OFF_W'(1);
                if (word_offset == OFF_LAST)
                begin
                    reference_crc_next = crc_fold(crc_in, pat_word[7:0]);
                    running_crc_next   = CRC_INIT;
                    word_offset_next   = '0;
                    pat_idx_next       = '0;
                    phase_next         = PH_READ;
                end
            end
            PH_READ:
            begin
                if (word_offset != OFF_END)
                begin
                    result.access_kind    = KIND_READ;
                    result.access_address = addr;
                    word_offset_next      = word_offset + OFF_W'(1);
                    read_pending_next     = 1'b1;
                end
                else
                begin
                    result.block_done   = 1'b1;
                    result.block_pass   = (crc_in == reference_crc);
                    result.block_number = current_block;
                    current_block_next  = current_block + BLOCK_W'(1);
                    word_offset_next    = '0;
                    running_crc_next    = CRC_INIT;
                    if (block_plus_one >= eff_count)
                    begin
                        phase_next       = PH_DONE;
                        result.test_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_WRITE;
                    end
                end
            end
            default:
            begin
                result.test_done = 1'b1;
            end
        endcase
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the sram block test sequencer: every read-data transfer is run
// through a local model of the write/read/report sequence and its crc-16
// signatures, and each result transfer is compared field by field. Read data
// mostly returns the written pattern, with corrupted bytes in one block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srbt_pkg::*;

    localparam int STALL_LIMIT = 4000;

    // entry 0 in the low bits
    localparam logic [255:0] PATTERN_WORDS = {
        16'h8800, 16'h4400, 16'h2200, 16'h1100, 16'h0088, 16'h0044, 16'h0022, 16'h0011,
        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hEFEF, 16'h0101, 16'hA5A5, 16'h5A5A
    };

    typedef struct packed {
        logic [15:0] rd;
        logic        typed;
        logic [1:0]  kind;
        logic [17:0] addr;
        logic [15:0] wdata;
    } vector_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // sequencer model state
    logic [1:0]  seq_phase = PH_WRITE;
    logic [8:0]  seq_offset = '0;
    logic [9:0]  seq_block = '0;
    logic [15:0] sig_crc = CRC_INIT;
    logic [15:0] golden_sig = '0;
    logic        rd_waiting = 1'b0;
    logic [10:0] blocks_cfg = COUNT_RESET;

    srbt_result_t expected_q[$];
    vector_t      directed [16];
    bit           calm = 1'b0;
    int           mismatches = 0;
    int           stall_cycles = 0;

    sram_block_test_crc_signature u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // msb-first crc-16/ccitt, polynomial 0x1021
    function automatic logic [15:0] ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        return c;
    endfunction

    function automatic srbt_result_t advance_sequencer(input logic [15:0] rd);
        srbt_result_t r;
        logic [10:0]  limit;
        logic [15:0]  w;
        r = '0;
        if (rd_waiting)
            sig_crc = ccitt_byte(sig_crc, rd[7:0]);
        rd_waiting = 1'b0;
        limit = (blocks_cfg == 0) ? 11'd1 : ((blocks_cfg > COUNT_MAX) ? COUNT_MAX : blocks_cfg);
        case (seq_phase)
            PH_WRITE:
            begin
                w = PATTERN_WORDS[{seq_offset[3:0], 4'd0} +: 16];
                r.access_kind = KIND_WRITE;
                r.access_address = {seq_block, seq_offset[7:0]};
                r.write_data = w;
                sig_crc = ccitt_byte(sig_crc, w[7:0]);
                seq_offset = seq_offset + 9'd1;
                if (seq_offset == 9'd256)
                begin
                    golden_sig = sig_crc;
                    sig_crc = CRC_INIT;
                    seq_offset = '0;
                    seq_phase = PH_READ;
                end
            end
            PH_READ:
            begin
                if (seq_offset < 9'd256)
                begin
                    r.access_kind = KIND_READ;
                    r.access_address = {seq_block, seq_offset[7:0]};
                    seq_offset = seq_offset + 9'd1;
                    rd_waiting = 1'b1;
                end
                else
                begin
                    // report cycle: no access, next block starts afterwards
                    r.block_done = 1'b1;
                    r.block_pass = (sig_crc == golden_sig);
                    r.block_number = seq_block;
                    seq_block = seq_block + 10'd1;
                    seq_offset = '0;
                    sig_crc = CRC_INIT;
                    if ({1'b0, r.block_number} + 11'd1 >= limit)
                    begin
                        seq_phase = PH_DONE;
                        r.test_done = 1'b1;
                    end
                    else
                        seq_phase = PH_WRITE;
                end
            end
            default:
                r.test_done = 1'b1;
        endcase
        return r;
    endfunction

    // good read data echoes the pattern low byte of the outstanding read
    function automatic logic [15:0] next_read_word(input int corrupt_odds);
        logic [3:0] entry;
        logic [7:0] low;
        entry = seq_offset[3:0] - 4'd1;
        low = PATTERN_WORDS[{entry, 4'd0} +: 8];
        if (rd_waiting && !(corrupt_odds > 0 && $urandom_range(corrupt_odds - 1) == 0))
            return {8'($urandom), low};
        return 16'($urandom);
    endfunction

    task automatic send_word(input logic [15:0] word, input logic typed,
                             input srbt_result_t pinned);
        srbt_result_t want;
        if (!calm)
        begin
            while ($urandom_range(99) < 28)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = advance_sequencer(word);
        expected_q.push_back(typed ? pinned : want);
    endtask

    task automatic run_items(input int count, input int corrupt_odds);
        repeat (count)
            send_word(next_read_word(corrupt_odds), 1'b0, '0);
    endtask

    // only while nothing is in flight; each transfer yields exactly one result
    task automatic program_count(input logic [10:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        blocks_cfg = value;
    endtask

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 28);

    always @(posedge clk)
    begin : check_result
        srbt_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result transfer with nothing expected: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tuser != want.access_kind)
                begin
                    $error("access_kind: expected %0d, got %0d", want.access_kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[17:0] != want.access_address)
                begin
                    $error("access_address: expected %h, got %h",
                           want.access_address, m_axis_tdata[17:0]);
                    mismatches++;
                end
                if (m_axis_tdata[33:18] != want.write_data)
                begin
                    $error("write_data: expected %h, got %h", want.write_data, m_axis_tdata[33:18]);
                    mismatches++;
                end
                if (m_axis_tdata[34] != want.block_done)
                begin
                    $error("block_done: expected %0d, got %0d", want.block_done, m_axis_tdata[34]);
                    mismatches++;
                end
                if (m_axis_tdata[35] != want.block_pass)
                begin
                    $error("block_pass: expected %0d, got %0d", want.block_pass, m_axis_tdata[35]);
                    mismatches++;
                end
                if (m_axis_tdata[45:36] != want.block_number)
                begin
                    $error("block_number: expected %0d, got %0d",
                           want.block_number, m_axis_tdata[45:36]);
                    mismatches++;
                end
                if (m_axis_tdata[46] != want.test_done)
                begin
                    $error("test_done: expected %0d, got %0d", want.test_done, m_axis_tdata[46]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** sram_block_test_crc_signature: FAILED **");
            $finish;
        end
    end

    initial
    begin
        vector_t      row;
        srbt_result_t pinned;

        // first sixteen writes of block 0, read data ignored here
        directed[0]  = '{16'h0000, 1'b1, KIND_WRITE, 18'd0,  16'h5A5A};
        directed[1]  = '{16'hFFFF, 1'b1, KIND_WRITE, 18'd1,  16'hA5A5};
        directed[2]  = '{16'hAAAA, 1'b1, KIND_WRITE, 18'd2,  16'h0101};
        directed[3]  = '{16'h5555, 1'b1, KIND_WRITE, 18'd3,  16'hEFEF};
        directed[4]  = '{16'h0001, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[5]  = '{16'h8000, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[6]  = '{16'h00FF, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[7]  = '{16'hFF00, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[8]  = '{16'h1234, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[9]  = '{16'hFEDC, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[10] = '{16'h0F0F, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[11] = '{16'hF0F0, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[12] = '{16'h7FFF, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[13] = '{16'hFFFE, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[14] = '{16'h3C3C, 1'b0, KIND_NONE,  18'd0,  16'h0000};
        directed[15] = '{16'hC3C3, 1'b1, KIND_WRITE, 18'd15, 16'h8800};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 16; i++)
        begin
            row = directed[i];
            pinned = '0;
            pinned.access_kind = row.kind;
            pinned.access_address = row.addr;
            pinned.write_data = row.wdata;
            send_word(row.rd, row.typed, pinned);
        end

        // out-of-range count behaves as 1024
        program_count(11'd2047);
        run_items(300, 0);
        program_count(COUNT_MAX);
        calm = 1'b1;
        run_items(300, 0);
        calm = 1'b0;
        // block 1 gets corrupted read bytes
        program_count(11'd3);
        run_items(450, 40);
        program_count(11'd1);
        run_items(300, 0);
        // zero acts as one: test ends at the block 2 report
        program_count(11'd0);
        run_items(300, 0);
        program_count(COUNT_MAX);
        run_items(100, 20);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** sram_block_test_crc_signature: PASSED **");
        else
            $display("** sram_block_test_crc_signature: FAILED **");
        $finish;
    end

endmodule
